/* rtl/aiaf_pkg.sv */
`default_nettype none

package aiaf_pkg;

  // Operation codes carried in the mode field
  localparam logic [3:0] MODE_LDA    = 4'd0;
  localparam logic [3:0] MODE_LDX    = 4'd1;
  localparam logic [3:0] MODE_LDY    = 4'd2;
  localparam logic [3:0] MODE_SETP   = 4'd3;
  localparam logic [3:0] MODE_ADD    = 4'd4;
  localparam logic [3:0] MODE_SUB    = 4'd5;
  localparam logic [3:0] MODE_CMPA   = 4'd6;
  localparam logic [3:0] MODE_CMPX   = 4'd7;
  localparam logic [3:0] MODE_CMPY   = 4'd8;
  localparam logic [3:0] MODE_BIT    = 4'd9;
  localparam logic [3:0] MODE_ACCCHG = 4'd10;
  localparam logic [3:0] MODE_MEMCHG = 4'd11;

  // Change kinds for increment/decrement/shift/rotate
  localparam logic [2:0] CHG_INC = 3'd0;
  localparam logic [2:0] CHG_DEC = 3'd1;
  localparam logic [2:0] CHG_SHL = 3'd2;
  localparam logic [2:0] CHG_SHR = 3'd3;
  localparam logic [2:0] CHG_ROL = 3'd4;

  // Status bit positions
  localparam int unsigned FLAG_N_BIT = 7;
  localparam int unsigned FLAG_V_BIT = 6;
  localparam int unsigned FLAG_M_BIT = 5;
  localparam int unsigned FLAG_X_BIT = 4;
  localparam int unsigned FLAG_Z_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  // Masks that clear groups of status bits
  localparam logic [7:0] CLR_NZ   = 8'h7d;
  localparam logic [7:0] CLR_VC   = 8'hbe;
  localparam logic [7:0] CLR_NVZ  = 8'h3d;

  // One operation request
  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] operand;
    logic        op_wide;
    logic [2:0]  chg_sel;
  } aiaf_item_t;

  // Architectural register file
  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  flags;
  } aiaf_regs_t;

endpackage

`default_nettype wire

/* rtl/aiaf_if.sv */
`default_nettype none

// Operation request channel
interface aiaf_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [15:0] operand;
  logic        op_wide;
  logic [2:0]  chg_sel;

  modport source (output valid, mode, operand, op_wide, chg_sel, input ready);
  modport sink   (input valid, mode, operand, op_wide, chg_sel, output ready);
endinterface

// Result channel
interface aiaf_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] acc_out;
  logic [15:0] index_x_out;
  logic [15:0] index_y_out;
  logic [7:0]  flags_out;
  logic [15:0] mem_result;

  modport source (output valid, acc_out, index_x_out, index_y_out, flags_out, mem_result,
                  input ready);
  modport sink   (input valid, acc_out, index_x_out, index_y_out, flags_out, mem_result,
                  output ready);
endinterface

`default_nettype wire

/* rtl/accumulator_index_alu_flags_top.sv */
`default_nettype none

// Channel  Direction  Payload
// cmd      in         mode, operand, op_wide, chg_sel
// res      out        acc_out, index_x_out, index_y_out, flags_out, mem_result
//
// A request is captured in an input register; from there it runs through
// the ALU against the architectural registers and lands in the result register.
// One request per cycle is sustained while the result channel does not stall.
// Registers and status update once per request, so flags feed the next one directly.
// A stalled result holds the ALU stage; cmd.ready drops only when both stages are full.
// Reset (rst, synchronous) clears A, X, Y, status and both valid flags.

module accumulator_index_alu_flags_top (
  input  wire       clk,
  input  wire       rst,
  aiaf_cmd_if.sink  cmd,
  aiaf_res_if.source res
);
  import aiaf_pkg::*;

  logic       s1_valid;
  aiaf_item_t s1_item;
  aiaf_regs_t regs;
  aiaf_regs_t regs_next;
  logic [15:0] mem_next;
  logic       advance;

  assign advance   = s1_valid & (~res.valid | res.ready);
  assign cmd.ready = ~s1_valid | ~res.valid | res.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item <= '{mode: cmd.mode, operand: cmd.operand, op_wide: cmd.op_wide,
                   chg_sel: cmd.chg_sel};
    end
  end

  aiaf_alu u_alu (
    .item       (s1_item),
    .regs       (regs),
    .regs_next  (regs_next),
    .mem_result (mem_next)
  );

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (advance) begin
      regs <= regs_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.acc_out     <= regs_next.acc;
      res.index_x_out <= regs_next.x;
      res.index_y_out <= regs_next.y;
      res.flags_out   <= regs_next.flags;
      res.mem_result  <= mem_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/aiaf_alu.sv */
`default_nettype none

module aiaf_alu (
  input  aiaf_pkg::aiaf_item_t item,
  input  aiaf_pkg::aiaf_regs_t regs,
  output aiaf_pkg::aiaf_regs_t regs_next,
  output logic [15:0]          mem_result
);
  import aiaf_pkg::*;

  // Update N and Z from a value at the given width
  function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [15:0] v,
                                        input logic wide);
    logic [7:0] r;
    r = f & CLR_NZ;
    if (wide) begin
      r[FLAG_Z_BIT] = (v == 16'h0000);
      r[FLAG_N_BIT] = v[15];
    end else begin
      r[FLAG_Z_BIT] = (v[7:0] == 8'h00);
      r[FLAG_N_BIT] = v[7];
    end
    return r;
  endfunction

  function automatic logic [15:0] width_mask(input logic [15:0] v, input logic wide);
    return wide ? v : {8'h00, v[7:0]};
  endfunction

  logic        acc_wide;
  logic        idx_wide;
  logic        cin;

  // Shared change unit (inc/dec/shift/rotate) for accumulator and memory
  logic [15:0] chg_old;
  logic        chg_wide;
  logic [15:0] chg_val;
  logic [7:0]  chg_flags;

  // Adder for add/subtract
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [16:0] add_sum;
  logic        add_sign_a;
  logic        add_sign_b;
  logic        add_sign_s;
  logic        add_carry;

  // Compare path
  logic [15:0] cmp_reg;
  logic [15:0] cmp_r;
  logic [15:0] cmp_o;
  logic [15:0] cmp_diff;

  assign acc_wide = ~regs.flags[FLAG_M_BIT];
  assign idx_wide = ~regs.flags[FLAG_X_BIT];
  assign cin      = regs.flags[FLAG_C_BIT];

  // Change unit
  always_comb begin
    chg_old   = (item.mode == MODE_MEMCHG) ? item.operand : regs.acc;
    chg_wide  = (item.mode == MODE_MEMCHG) ? item.op_wide : acc_wide;
    chg_flags = regs.flags;
    case (item.chg_sel)
      CHG_INC: chg_val = width_mask(chg_old + 16'd1, chg_wide);
      CHG_DEC: chg_val = width_mask(chg_old - 16'd1, chg_wide);
      CHG_SHL: begin
        chg_val = width_mask({chg_old[14:0], 1'b0}, chg_wide);
        chg_flags[FLAG_C_BIT] = chg_wide ? chg_old[15] : chg_old[7];
      end
      CHG_SHR: begin
        chg_val = width_mask(chg_old, chg_wide) >> 1;
        chg_flags[FLAG_C_BIT] = chg_old[0];
      end
      CHG_ROL: begin
        chg_val = width_mask({chg_old[14:0], cin}, chg_wide);
        chg_flags[FLAG_C_BIT] = chg_wide ? chg_old[15] : chg_old[7];
      end
      default: chg_val = 16'h0000;
    endcase
    chg_flags = set_nz(chg_flags, chg_val, chg_wide);
  end

  // Binary add; subtract adds the ones' complement
  always_comb begin
    add_a      = width_mask(regs.acc, acc_wide);
    add_b      = width_mask((item.mode == MODE_SUB) ? ~item.operand : item.operand, acc_wide);
    add_sum    = {1'b0, add_a} + {1'b0, add_b} + {16'h0000, cin};
    add_sign_a = acc_wide ? add_a[15] : add_a[7];
    add_sign_b = acc_wide ? add_b[15] : add_b[7];
    add_sign_s = acc_wide ? add_sum[15] : add_sum[7];
    add_carry  = acc_wide ? add_sum[16] : add_sum[8];
  end

  // Compare subtract at the requested width
  always_comb begin
    case (item.mode)
      MODE_CMPX: cmp_reg = regs.x;
      MODE_CMPY: cmp_reg = regs.y;
      default:   cmp_reg = regs.acc;
    endcase
    cmp_r    = width_mask(cmp_reg, item.op_wide);
    cmp_o    = width_mask(item.operand, item.op_wide);
    cmp_diff = cmp_r - cmp_o;
  end

  // Per-operation register update
  always_comb begin
    regs_next  = regs;
    mem_result = 16'h0000;
    case (item.mode)
      MODE_LDA: begin
        regs_next.acc   = acc_wide ? item.operand : {regs.acc[15:8], item.operand[7:0]};
        regs_next.flags = set_nz(regs.flags, regs_next.acc, acc_wide);
      end
      MODE_LDX: begin
        regs_next.x     = width_mask(item.operand, idx_wide);
        regs_next.flags = set_nz(regs.flags, regs_next.x, idx_wide);
      end
      MODE_LDY: begin
        regs_next.y     = width_mask(item.operand, idx_wide);
        regs_next.flags = set_nz(regs.flags, regs_next.y, idx_wide);
      end
      MODE_SETP: begin
        regs_next.flags = item.operand[7:0];
        if (item.operand[FLAG_X_BIT]) begin
          regs_next.x = {8'h00, regs.x[7:0]};
          regs_next.y = {8'h00, regs.y[7:0]};
        end
      end
      MODE_ADD, MODE_SUB: begin
        regs_next.acc   = acc_wide ? add_sum[15:0] : {regs.acc[15:8], add_sum[7:0]};
        regs_next.flags = set_nz(regs.flags, regs_next.acc, acc_wide) & CLR_VC;
        regs_next.flags[FLAG_V_BIT] = ~(add_sign_a ^ add_sign_b) & (add_sign_a ^ add_sign_s);
        regs_next.flags[FLAG_C_BIT] = add_carry;
      end
      MODE_CMPA, MODE_CMPX, MODE_CMPY: begin
        regs_next.flags = set_nz(regs.flags, cmp_diff, item.op_wide);
        regs_next.flags[FLAG_C_BIT] = (cmp_r >= cmp_o);
      end
      MODE_BIT: begin
        regs_next.flags = regs.flags & CLR_NVZ;
        regs_next.flags[FLAG_Z_BIT] =
          (width_mask(regs.acc & item.operand, acc_wide) == 16'h0000);
        regs_next.flags[FLAG_N_BIT] = acc_wide ? item.operand[15] : item.operand[7];
        regs_next.flags[FLAG_V_BIT] = acc_wide ? item.operand[14] : item.operand[6];
      end
      MODE_ACCCHG: begin
        regs_next.acc   = acc_wide ? chg_val : {regs.acc[15:8], chg_val[7:0]};
        regs_next.flags = chg_flags;
      end
      MODE_MEMCHG: begin
        regs_next.flags = chg_flags;
        mem_result      = chg_val;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/aiaf_check.sv */
`default_nettype none

module aiaf_check (
  input wire        clk,
  input wire        rst,
  input wire        cmd_ready,
  input wire        res_valid,
  input wire        res_ready,
  input wire [15:0] acc_out,
  input wire [15:0] index_x_out,
  input wire [15:0] index_y_out,
  input wire [7:0]  flags_out
);
  import aiaf_pkg::*;

  // Last delivered result, for checks between consecutive results
  logic       prev_valid;
  logic       prev_m;
  logic [7:0] prev_acc_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      prev_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      prev_m      <= flags_out[FLAG_M_BIT];
      prev_acc_hi <= acc_out[15:8];
    end
  end

  // A pending result is held until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(acc_out) && $stable(flags_out))
    else $error("result changed while stalled");

  // With the result stage empty, a request can always enter
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("request blocked with empty result stage");

  // Narrow index mode keeps both index high bytes clear
  a_idx_narrow: assert property (@(posedge clk) disable iff (rst)
    res_valid && flags_out[FLAG_X_BIT] |->
      index_x_out[15:8] == 8'h00 && index_y_out[15:8] == 8'h00)
    else $error("index high byte set in narrow index mode");

  // In narrow accumulator mode the next result keeps the accumulator high byte
  a_acc_hi_kept: assert property (@(posedge clk) disable iff (rst)
    res_valid && prev_valid && prev_m |-> acc_out[15:8] == prev_acc_hi)
    else $error("accumulator high byte changed in narrow mode");

endmodule

bind accumulator_index_alu_flags_top aiaf_check u_aiaf_check (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .acc_out     (res.acc_out),
  .index_x_out (res.index_x_out),
  .index_y_out (res.index_y_out),
  .flags_out   (res.flags_out)
);

`default_nettype wire
